### design/matrix_inverse_4x4_unit_macros.svh
// assertion macros shared by the checking code
`ifndef MATRIX_INVERSE_4X4_UNIT_MACROS_SVH
`define MATRIX_INVERSE_4X4_UNIT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define MI4_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mi4 check failed");

// next-cycle implication, ignored while reset is high
`define MI4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mi4 check failed");

// next-cycle implication that also holds across reset
`define MI4_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mi4 check failed");

`endif

### design/mi4_pkg.sv
package mi4_pkg;

   localparam int ORDER     = 4;
   localparam int CELLS     = ORDER * ORDER;
   localparam int FRAC_BITS = 16;
   localparam int QUO_STEPS = 2 * FRAC_BITS;  // quotient bits below the overflow check

   localparam int ELEM_W  = 32;
   localparam int MINOR_W = 100;   // 3x3 minor, six products of three elements
   localparam int DET_W   = 132;   // 4x4 determinant, 24 products of four elements
   localparam int DABS_W  = 131;
   localparam int MP_W    = 128;   // multiplicand, taken 32 bits a step
   localparam int PR_W    = 160;

   localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef enum logic [13:0] {
      S_LOAD = 14'b00_0000_0000_0001,
      S_RD0  = 14'b00_0000_0000_0010,
      S_RD1  = 14'b00_0000_0000_0100,
      S_RD2  = 14'b00_0000_0000_1000,
      S_RD3  = 14'b00_0000_0001_0000,
      S_MUL  = 14'b00_0000_0010_0000,
      S_NEXT = 14'b00_0000_0100_0000,
      S_DRD0 = 14'b00_0000_1000_0000,
      S_DRD1 = 14'b00_0001_0000_0000,
      S_DCHK = 14'b00_0010_0000_0000,
      S_ORD0 = 14'b00_0100_0000_0000,
      S_ORD1 = 14'b00_1000_0000_0000,
      S_DIV  = 14'b01_0000_0000_0000,
      S_OUT  = 14'b10_0000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      PH_AB  = 2'd0,
      PH_ABC = 2'd1,
      PH_DET = 2'd2
   } phase_type;

   // index s of the 3 kept rows or columns when index skip is dropped
   function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] s);
      skip_idx = (s < skip) ? s : 2'(s + 2'd1);
   endfunction

   // column slot taken by row slot s in permutation p
   function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] s);
      logic [1:0] c;
      c = s;
      case (p)
         3'd1:    c = (s == 2'd0) ? 2'd1 : (s == 2'd1) ? 2'd2 : 2'd0;
         3'd2:    c = (s == 2'd0) ? 2'd2 : (s == 2'd1) ? 2'd0 : 2'd1;
         3'd3:    c = (s == 2'd0) ? 2'd0 : (s == 2'd1) ? 2'd2 : 2'd1;
         3'd4:    c = (s == 2'd0) ? 2'd2 : (s == 2'd1) ? 2'd1 : 2'd0;
         3'd5:    c = (s == 2'd0) ? 2'd1 : (s == 2'd1) ? 2'd0 : 2'd2;
         default: c = s;
      endcase
      perm_col = c;
   endfunction

   // odd permutations are the last three
   function automatic logic perm_neg(input logic [2:0] p);
      perm_neg = (p >= 3'd3);
   endfunction

endpackage

### design/matrix_inverse_4x4_unit.sv
// sequence: 16 load transactions, then the 16 cofactors, then the determinant, then
// one result per element, each from up to 32 divide steps (a singular matrix gives one
// flagged result); the work is serialised on the single 33x32 multiplier and the
// one-bit-per-cycle divider; req_tready is high only while loading, so no new matrix is taken before the last result
// reset: synchronous, active high; clears the sequencer, load count and output valid
module matrix_inverse_4x4_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] element
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser,   // [0] singular, [1] clipped
   output logic        rsp_tlast
);

   // sequencer and counters
   mi4_pkg::state_type state_ff, state_in;
   mi4_pkg::phase_type phase_ff, phase_in;
   logic [3:0] load_cnt_ff, load_cnt_in;
   logic [3:0] ci_ff, ci_in;          // cofactor index, also det column
   logic [2:0] perm_ff, perm_in;      // permutation of the 3x3 minor
   logic [1:0] k_ff, k_in;            // multiplicand chunk
   logic [1:0] nch_ff, nch_in;        // last chunk
   logic [4:0] step_ff, step_in;      // divide step
   logic [3:0] oidx_ff, oidx_in;      // result index

   // datapath registers
   logic [31:0]                      e_ff [3];
   logic [31:0]                      e_in [3];
   logic [mi4_pkg::MP_W-1:0]         mp_ff, mp_in;
   logic signed [31:0]               me_ff, me_in;
   logic [mi4_pkg::PR_W-1:0]         pr_ff, pr_in;
   logic [mi4_pkg::MINOR_W-1:0]      macc_ff, macc_in;
   logic [mi4_pkg::DET_W-1:0]        det_ff, det_in;
   logic                             dneg_ff, dneg_in;
   logic [mi4_pkg::DABS_W-1:0]       dabs_ff, dabs_in;
   logic [mi4_pkg::DABS_W-1:0]       rem_ff, rem_in;
   logic [31:0]                      quo_ff, quo_in;
   logic                             cneg_ff, cneg_in;
   logic                             big_ff, big_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   // element store and cofactor store
   logic [31:0]                 elem_mem [mi4_pkg::CELLS];
   logic [31:0]                 elem_rd_ff;
   logic [3:0]                  elem_addr;
   logic                        elem_we;
   logic [mi4_pkg::MINOR_W-1:0] cof_mem [mi4_pkg::CELLS];
   logic [mi4_pkg::MINOR_W-1:0] cof_rd_ff;
   logic [3:0]                  cof_addr;
   logic                        cof_we;

   // combinational helpers
   logic                        req_fire;
   logic                        out_free;
   logic [1:0]                  slot;
   logic [31:0]                 chunk;
   logic signed [32:0]          mul_a;
   logic signed [64:0]          mul_p;
   logic [mi4_pkg::PR_W-1:0]    mul_ext;
   logic [mi4_pkg::PR_W-1:0]    mul_sh;
   logic                        term_neg;
   logic [mi4_pkg::MINOR_W-1:0] minor_sum;
   logic [mi4_pkg::MINOR_W-1:0] cabs;
   logic [mi4_pkg::DABS_W-1:0]  rem_sh;
   logic                        rem_ge;
   logic [31:0]                 out_val;
   logic                        out_clip;

   assign req_tready = (state_ff == mi4_pkg::S_LOAD);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // shared 33x32 signed multiplier, one chunk of the multiplicand per cycle
   assign chunk   = mp_ff[32*k_ff +: 32];
   assign mul_a   = (k_ff == nch_ff) ? {chunk[31], chunk} : {1'b0, chunk};
   assign mul_p   = mul_a * me_ff;
   assign mul_ext = {{(mi4_pkg::PR_W-65){mul_p[64]}}, mul_p};

   always_comb begin
      case (k_ff)
         2'd0:    mul_sh = mul_ext;
         2'd1:    mul_sh = mul_ext << 32;
         2'd2:    mul_sh = mul_ext << 64;
         default: mul_sh = mul_ext << 96;
      endcase
   end

   // row slot being read for a 3x3 product term
   always_comb begin
      unique case (state_ff)
         mi4_pkg::S_RD1: slot = 2'd1;
         mi4_pkg::S_RD2: slot = 2'd2;
         default:        slot = 2'd0;
      endcase
   end

   // odd permutation, or odd cofactor position, flips the term
   assign term_neg = mi4_pkg::perm_neg(perm_ff) ^ ci_ff[2] ^ ci_ff[0];

   // running minor sum including the current product term
   assign minor_sum = term_neg ? (macc_ff - pr_ff[mi4_pkg::MINOR_W-1:0])
                               : (macc_ff + pr_ff[mi4_pkg::MINOR_W-1:0]);

   assign cabs   = cof_rd_ff[mi4_pkg::MINOR_W-1] ? (~cof_rd_ff + 1'b1) : cof_rd_ff;
   assign rem_sh = {rem_ff[mi4_pkg::DABS_W-2:0], 1'b0};
   assign rem_ge = (rem_sh >= dabs_ff);

   // sign and saturation of a finished quotient
   always_comb begin
      if (cneg_ff ^ dneg_ff) begin
         out_clip = big_ff | (quo_ff > mi4_pkg::NEG_MAX);
         out_val  = out_clip ? mi4_pkg::NEG_MAX : (32'd0 - quo_ff);
      end else begin
         out_clip = big_ff | (quo_ff > mi4_pkg::POS_MAX);
         out_val  = out_clip ? mi4_pkg::POS_MAX : quo_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      load_cnt_in  = load_cnt_ff;
      ci_in        = ci_ff;
      perm_in      = perm_ff;
      k_in         = k_ff;
      nch_in       = nch_ff;
      step_in      = step_ff;
      oidx_in      = oidx_ff;
      e_in         = e_ff;
      mp_in        = mp_ff;
      me_in        = me_ff;
      pr_in        = pr_ff;
      macc_in      = macc_ff;
      det_in       = det_ff;
      dneg_in      = dneg_ff;
      dabs_in      = dabs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cneg_in      = cneg_ff;
      big_in       = big_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      elem_we      = 1'b0;
      cof_we       = 1'b0;
      elem_addr    = {mi4_pkg::skip_idx(ci_ff[3:2], slot),
                      mi4_pkg::skip_idx(ci_ff[1:0], mi4_pkg::perm_col(perm_ff, slot))};
      cof_addr     = ci_ff;

      unique case (state_ff)
         mi4_pkg::S_LOAD: begin
            elem_addr = load_cnt_ff;
            if (req_fire) begin
               elem_we = 1'b1;
               if (load_cnt_ff == 4'(mi4_pkg::CELLS - 1)) begin
                  load_cnt_in = '0;
                  ci_in       = '0;
                  perm_in     = '0;
                  macc_in     = '0;
                  state_in    = mi4_pkg::S_RD0;
               end else begin
                  load_cnt_in = load_cnt_ff + 4'd1;
               end
            end
         end
         mi4_pkg::S_RD0: state_in = mi4_pkg::S_RD1;
         mi4_pkg::S_RD1: begin
            e_in[0]  = elem_rd_ff;
            state_in = mi4_pkg::S_RD2;
         end
         mi4_pkg::S_RD2: begin
            e_in[1]  = elem_rd_ff;
            state_in = mi4_pkg::S_RD3;
         end
         mi4_pkg::S_RD3: begin
            e_in[2]  = elem_rd_ff;
            mp_in    = {{(mi4_pkg::MP_W-32){e_ff[0][31]}}, e_ff[0]};
            me_in    = e_ff[1];
            pr_in    = '0;
            k_in     = '0;
            nch_in   = 2'd0;
            phase_in = mi4_pkg::PH_AB;
            state_in = mi4_pkg::S_MUL;
         end
         mi4_pkg::S_MUL: begin
            pr_in = pr_ff + mul_sh;
            k_in  = k_ff + 2'd1;
            if (k_ff == nch_ff) state_in = mi4_pkg::S_NEXT;
         end
         mi4_pkg::S_NEXT: begin
            unique case (phase_ff)
               mi4_pkg::PH_AB: begin
                  mp_in    = pr_ff[mi4_pkg::MP_W-1:0];
                  me_in    = e_ff[2];
                  pr_in    = '0;
                  k_in     = '0;
                  nch_in   = 2'd1;
                  phase_in = mi4_pkg::PH_ABC;
                  state_in = mi4_pkg::S_MUL;
               end
               mi4_pkg::PH_ABC: begin
                  macc_in = minor_sum;
                  if (perm_ff == 3'd5) begin
                     // minor finished: store it and start the next one from zero
                     cof_we  = 1'b1;
                     macc_in = '0;
                     perm_in = '0;
                     if (ci_ff == 4'(mi4_pkg::CELLS - 1)) begin
                        ci_in    = '0;
                        det_in   = '0;
                        state_in = mi4_pkg::S_DRD0;
                     end else begin
                        ci_in    = ci_ff + 4'd1;
                        state_in = mi4_pkg::S_RD0;
                     end
                  end else begin
                     perm_in  = perm_ff + 3'd1;
                     state_in = mi4_pkg::S_RD0;
                  end
               end
               mi4_pkg::PH_DET: begin
                  det_in = det_ff + pr_ff[mi4_pkg::DET_W-1:0];
                  if (ci_ff == 4'(mi4_pkg::ORDER - 1)) begin
                     state_in = mi4_pkg::S_DCHK;
                  end else begin
                     ci_in    = ci_ff + 4'd1;
                     state_in = mi4_pkg::S_DRD0;
                  end
               end
               default: state_in = mi4_pkg::S_LOAD;
            endcase
         end
         mi4_pkg::S_DRD0: begin
            // expansion along row 0: element (0, j) times cofactor (0, j)
            elem_addr = {2'd0, ci_ff[1:0]};
            cof_addr  = {2'd0, ci_ff[1:0]};
            state_in  = mi4_pkg::S_DRD1;
         end
         mi4_pkg::S_DRD1: begin
            mp_in    = {{(mi4_pkg::MP_W-mi4_pkg::MINOR_W){cof_rd_ff[mi4_pkg::MINOR_W-1]}},
                        cof_rd_ff};
            me_in    = elem_rd_ff;
            pr_in    = '0;
            k_in     = '0;
            nch_in   = 2'd3;
            phase_in = mi4_pkg::PH_DET;
            state_in = mi4_pkg::S_MUL;
         end
         mi4_pkg::S_DCHK: begin
            if (det_ff == '0) begin
               // singular matrix: one result, flagged
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_user_in  = 2'b01;
                  rsp_last_in  = 1'b1;
                  state_in     = mi4_pkg::S_LOAD;
               end
            end else begin
               dneg_in  = det_ff[mi4_pkg::DET_W-1];
               dabs_in  = det_ff[mi4_pkg::DET_W-1] ? mi4_pkg::DABS_W'(~det_ff + 1'b1)
                                                   : det_ff[mi4_pkg::DABS_W-1:0];
               oidx_in  = '0;
               state_in = mi4_pkg::S_ORD0;
            end
         end
         mi4_pkg::S_ORD0: begin
            // inverse (r, c) uses cofactor (c, r)
            cof_addr = {oidx_ff[1:0], oidx_ff[3:2]};
            state_in = mi4_pkg::S_ORD1;
         end
         mi4_pkg::S_ORD1: begin
            // quotient needs more than 32 bits exactly when |cof| >= |det|
            cneg_in = cof_rd_ff[mi4_pkg::MINOR_W-1];
            big_in  = ({(mi4_pkg::DABS_W-mi4_pkg::MINOR_W)'(0), cabs} >= dabs_ff);
            rem_in  = {(mi4_pkg::DABS_W-mi4_pkg::MINOR_W)'(0), cabs};
            quo_in  = '0;
            step_in = '0;
            if ({(mi4_pkg::DABS_W-mi4_pkg::MINOR_W)'(0), cabs} >= dabs_ff) begin
               state_in = mi4_pkg::S_OUT;
            end else begin
               state_in = mi4_pkg::S_DIV;
            end
         end
         mi4_pkg::S_DIV: begin
            rem_in  = rem_ge ? (rem_sh - dabs_ff) : rem_sh;
            quo_in  = {quo_ff[30:0], rem_ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(mi4_pkg::QUO_STEPS - 1)) state_in = mi4_pkg::S_OUT;
         end
         mi4_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_val;
               rsp_user_in  = {out_clip, 1'b0};
               rsp_last_in  = (oidx_ff == 4'(mi4_pkg::CELLS - 1));
               if (oidx_ff == 4'(mi4_pkg::CELLS - 1)) begin
                  state_in = mi4_pkg::S_LOAD;
               end else begin
                  oidx_in  = oidx_ff + 4'd1;
                  state_in = mi4_pkg::S_ORD0;
               end
            end
         end
         default: state_in = mi4_pkg::S_LOAD;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mi4_pkg::S_LOAD;
         phase_ff     <= mi4_pkg::PH_AB;
         load_cnt_ff  <= '0;
         ci_ff        <= '0;
         perm_ff      <= '0;
         k_ff         <= '0;
         nch_ff       <= '0;
         step_ff      <= '0;
         oidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         load_cnt_ff  <= load_cnt_in;
         ci_ff        <= ci_in;
         perm_ff      <= perm_in;
         k_ff         <= k_in;
         nch_ff       <= nch_in;
         step_ff      <= step_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      mp_ff       <= mp_in;
      me_ff       <= me_in;
      pr_ff       <= pr_in;
      macc_ff     <= macc_in;
      det_ff      <= det_in;
      dneg_ff     <= dneg_in;
      dabs_ff     <= dabs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cneg_ff     <= cneg_in;
      big_ff      <= big_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // element store
   always_ff @(posedge clock) begin
      if (elem_we) elem_mem[load_cnt_ff] <= req_tdata;
      elem_rd_ff <= elem_mem[elem_addr];
   end

   // cofactor store, written with the finished minor sum
   always_ff @(posedge clock) begin
      if (cof_we) cof_mem[ci_ff] <= minor_sum;
      cof_rd_ff <= cof_mem[cof_addr];
   end

endmodule

### design/mi4_checker.sv
`include "matrix_inverse_4x4_unit_macros.svh"

module mi4_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result transaction holds its payload
   `MI4_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a singular result is the only and last one, with zero value
   `MI4_ASSERT_NOW(a_singular, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tlast && (rsp_tdata == 32'd0) && !rsp_tuser[1])

   // clipped results carry one of the two saturation codes
   `MI4_ASSERT_NOW(a_clip_code, clock, reset, rsp_tvalid && rsp_tuser[1],
      (rsp_tdata == 32'h7fff_ffff) || (rsp_tdata == 32'h8000_0000))

   // after reset the block is loading and has nothing to deliver
   `MI4_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind matrix_inverse_4x4_unit mi4_checker u_mi4_checker (.*);
